FILE: rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the star stencil accumulator
// Beat layouts of both channels, the tag that rides the cell chain, register
// indexes and reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  // Q16.16 data path
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;

  // field widths
  localparam int SLOT_W    = 4;
  localparam int COL_OUT_W = 10;
  localparam int ROW_W     = 12;

  // configuration register widths
  localparam int GW_W = 11;
  localparam int FC_W = 10;
  localparam int EC_W = 11;
  localparam int FR_W = 12;
  localparam int ER_W = 13;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_COL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_ROW    = 3'd4;

  // register reset values
  localparam logic [GW_W-1:0] GW_RST = 11'd1024;
  localparam logic [FC_W-1:0] FC_RST = 10'd2;
  localparam logic [EC_W-1:0] EC_RST = 11'd1022;
  localparam logic [FR_W-1:0] FR_RST = 12'd2;
  localparam logic [ER_W-1:0] ER_RST = 13'd4094;

  // opcodes
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [SLOT_W-1:0]        weight_slot;
    logic signed [DATA_W-1:0] weight_value;
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] prior_out;
  } sst_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [COL_OUT_W-1:0]     out_col;
    logic [ROW_W-1:0]         out_row;
    logic                     clipped;
  } sst_out_t;

  // per-beat control carried along the cell chain
  typedef struct packed {
    logic                     load;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] wval;
    logic                     emit;
    logic [COL_OUT_W-1:0]     col;
    logic [ROW_W-1:0]         row;
  } sst_tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram: generic RAM, one write port and two registered read ports
// A read in the same cycle as a write to that address returns the old word.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered reads, hold when not enabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

FILE: rtl/core/sst_window.sv
// ----------------------------------------------------------------------------
// sst_window: raster counters, line stores and stencil operand gathering
// Tracks the grid position, writes each sample into its row store, reads the
// vertical arm and the horizontal neighbors, and hands one operand set per
// beat to the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_window #(
  parameter int RADIUS = 2,
  parameter int MAX_WIDTH = 1024,
  localparam int NW = 4 * RADIUS + 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [sst_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  sst_pkg::sst_in_t                       in_data,
  output logic                                   dn_valid,
  input  logic                                   dn_stall,
  output sst_pkg::sst_tag_t                      dn_tag,
  output logic [NW-1:0][sst_pkg::DATA_W-1:0]     dn_ops,
  output logic signed [sst_pkg::DATA_W-1:0]      dn_prior
);

  import sst_pkg::*;

  localparam int ROWS  = 2 * RADIUS;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int RS_W  = $clog2(ROWS);
  localparam int CMP_W = ((COL_W > EC_W) ? COL_W : EC_W) + 1;
  localparam int RHN   = (RADIUS > 1) ? RADIUS - 1 : 1;

  // configuration registers
  logic [GW_W-1:0] gw_r;
  logic [FC_W-1:0] fc_r;
  logic [EC_W-1:0] ec_r;
  logic [FR_W-1:0] fr_r;
  logic [ER_W-1:0] er_r;

  // position of the next sample and its row store
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [RS_W-1:0]  rs_r;

  // stage 1
  logic                     s1_v_r;
  sst_tag_t                 s1_tag_r;
  logic signed [DATA_W-1:0] s1_samp_r;
  logic signed [DATA_W-1:0] s1_prior_r;
  logic [RS_W-1:0]          s1_rs_r;

  // horizontal arm history of the center row
  logic [DATA_W-1:0] lh_r [RADIUS];
  logic [DATA_W-1:0] rh_r [RHN];

  logic              acc;
  logic              samp;
  logic              take;
  logic              s1_adv;
  logic              push;
  logic [CMP_W-1:0]  w_eff;
  logic [CMP_W-1:0]  x_c;
  logic [CMP_W-1:0]  xr;
  logic [CMP_W-1:0]  rb_c;
  logic [COL_W-1:0]  addr_b;
  logic              row_end;
  logic              in_win;
  logic              col_ok;
  logic              row_ok;
  logic              emit;
  logic [ROW_W-1:0]  py;
  logic [RS_W:0]     h_sum;
  logic [RS_W-1:0]   h_sel;
  logic [DATA_W-1:0] row_a;
  logic [DATA_W-1:0] row_b;
  logic [DATA_W-1:0] rd_a [ROWS];
  logic [DATA_W-1:0] rd_b [ROWS];

  // take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GW_RST;
      fc_r <= FC_RST;
      ec_r <= EC_RST;
      fr_r <= FR_RST;
      er_r <= ER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_WIDTH: gw_r <= cfg_wdata[GW_W-1:0];
        REG_FIRST_COL:  fc_r <= cfg_wdata[FC_W-1:0];
        REG_END_COL:    ec_r <= cfg_wdata[EC_W-1:0];
        REG_FIRST_ROW:  fr_r <= cfg_wdata[FR_W-1:0];
        REG_END_ROW:    er_r <= cfg_wdata[ER_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = !s1_v_r || !dn_stall;
  assign in_stall = !s1_adv;
  assign acc      = in_valid && !in_stall;
  assign samp     = (in_data.opcode == OP_SAMPLE);
  assign take     = acc && samp;

  // clamp the row length to 1..MAX_WIDTH
  always_comb begin
    if (gw_r == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(gw_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(gw_r);
    end
  end

  // decide whether the point RADIUS rows up is computed
  assign x_c     = CMP_W'(col_r);
  assign xr      = x_c + CMP_W'(RADIUS);
  assign row_end = (x_c + CMP_W'(1)) >= w_eff;
  assign py      = row_r - ROW_W'(RADIUS);
  assign in_win  = (row_r >= ROW_W'(ROWS)) && (x_c >= CMP_W'(RADIUS)) && (xr < w_eff);
  assign col_ok  = (x_c >= CMP_W'(fc_r)) && (x_c < CMP_W'(ec_r));
  assign row_ok  = (ER_W'(py) >= ER_W'(fr_r)) && (ER_W'(py) < er_r);
  assign emit    = in_win && col_ok && row_ok;

  // right-arm read address, wrapped into the store
  assign rb_c   = (xr >= CMP_W'(MAX_WIDTH)) ? (xr - CMP_W'(MAX_WIDTH)) : xr;
  assign addr_b = rb_c[COL_W-1:0];

  // advance the raster position on each sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rs_r  <= '0;
    end else if (take) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
        if ((&row_r) || (rs_r == RS_W'(ROWS - 1))) begin
          rs_r <= '0;
        end else begin
          rs_r <= rs_r + RS_W'(1);
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // one store per buffered row
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    sst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .we      (take && (rs_r == RS_W'(r))),
      .waddr   (col_r),
      .wdata   (in_data.sample),
      .re_a    (take),
      .raddr_a (col_r),
      .rdata_a (rd_a[r]),
      .re_b    (take),
      .raddr_b (addr_b),
      .rdata_b (rd_b[r])
    );
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_tag_r.load <= !samp;
      s1_tag_r.slot <= in_data.weight_slot;
      s1_tag_r.wval <= in_data.weight_value;
      s1_tag_r.emit <= samp && emit;
      s1_tag_r.col  <= COL_OUT_W'(col_r);
      s1_tag_r.row  <= py;
      s1_samp_r     <= in_data.sample;
      s1_prior_r    <= in_data.prior_out;
      s1_rs_r       <= rs_r;
    end
  end

  // center row store
  assign h_sum = {1'b0, s1_rs_r} + (RS_W + 1)'(RADIUS);
  assign h_sel = (h_sum >= (RS_W + 1)'(ROWS)) ? RS_W'(h_sum - (RS_W + 1)'(ROWS))
                                               : h_sum[RS_W-1:0];
  assign row_a = rd_a[h_sel];
  assign row_b = rd_b[h_sel];

  // shift the horizontal history when a sample leaves stage 1
  assign push = s1_v_r && !dn_stall && !s1_tag_r.load;

  always_ff @(posedge clk) begin
    if (push) begin
      lh_r[0] <= row_a;
      for (int i = 1; i < RADIUS; i++) begin
        lh_r[i] <= lh_r[i-1];
      end
      rh_r[0] <= row_b;
      for (int i = 1; i < RHN; i++) begin
        rh_r[i] <= rh_r[i-1];
      end
    end
  end

  // gather operands in weight-slot order
  always_comb begin
    logic [RS_W:0] vsum;
    int            d;
    dn_ops = '0;
    for (int k = 0; k < ROWS; k++) begin
      vsum = {1'b0, s1_rs_r} + (RS_W + 1)'(k);
      if (vsum >= (RS_W + 1)'(ROWS)) begin
        vsum = vsum - (RS_W + 1)'(ROWS);
      end
      dn_ops[k] = rd_a[vsum[RS_W-1:0]];
    end
    dn_ops[ROWS] = s1_samp_r;
    for (int j = 0; j < RADIUS; j++) begin
      dn_ops[ROWS + 1 + j] = lh_r[RADIUS - 1 - j];
      d = RADIUS - 1 - j;
      if (d == 0) begin
        dn_ops[3 * RADIUS + 1 + j] = row_b;
      end else begin
        dn_ops[3 * RADIUS + 1 + j] = rh_r[d - 1];
      end
    end
  end

  assign dn_valid = s1_v_r;
  assign dn_tag   = s1_tag_r;
  assign dn_prior = s1_prior_r;

  // weight loads leave the raster position alone
  a_load_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !samp) |=> ($stable(col_r) && $stable(row_r) && $stable(rs_r)))
    else $error("weight load moved the raster position");

  // last column of a row restarts the column count
  a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (take && row_end) |=> (col_r == '0))
    else $error("column did not restart at row end");

  // grid wrap restarts the row store rotation
  a_grid_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (take && row_end && (&row_r)) |=> ((row_r == '0) && (rs_r == '0)))
    else $error("row store rotation not restarted at grid wrap");

  // mid-row samples keep the row and its store
  a_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !row_end) |=> ($stable(row_r) && $stable(rs_r)))
    else $error("row moved in mid-row");

endmodule

`default_nettype wire

FILE: rtl/core/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell: one multiply-accumulate cell of the stencil chain
// Holds one weight, multiplies its operand of the passing beat, and adds the
// product of the cell before it to the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_cell #(
  parameter int IDX = 0,
  parameter int NW = 9,
  parameter int SUM_W = 52
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_stall,
  input  sst_pkg::sst_tag_t                     up_tag,
  input  logic [NW-1:0][sst_pkg::DATA_W-1:0]    up_ops,
  input  logic signed [SUM_W-1:0]               up_sum,
  input  logic signed [sst_pkg::PROD_W-1:0]     up_prod,
  output logic                                  dn_valid,
  input  logic                                  dn_stall,
  output sst_pkg::sst_tag_t                     dn_tag,
  output logic [NW-1:0][sst_pkg::DATA_W-1:0]    dn_ops,
  output logic signed [SUM_W-1:0]               dn_sum,
  output logic signed [sst_pkg::PROD_W-1:0]     dn_prod
);

  import sst_pkg::*;

  logic                         v_r;
  sst_tag_t                     tag_r;
  logic [NW-1:0][DATA_W-1:0]    ops_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [DATA_W-1:0]     w_r;
  logic                         adv;
  logic                         hit;
  logic signed [2*DATA_W-1:0]   full;

  assign adv      = !v_r || !dn_stall;
  assign up_stall = !adv;
  assign hit      = up_tag.load && (32'(up_tag.slot) == IDX);

  // exact product; floor shift is the upper bits
  assign full = $signed(w_r) * $signed(up_ops[IDX]);

  // valid and weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      w_r <= '0;
    end else begin
      if (adv) begin
        v_r <= up_valid;
      end
      if (up_valid && adv && hit) begin
        w_r <= up_tag.wval;
      end
    end
  end

  // advance the beat
  always_ff @(posedge clk) begin
    if (up_valid && adv) begin
      tag_r  <= up_tag;
      ops_r  <= up_ops;
      sum_r  <= up_sum + SUM_W'(up_prod);
      prod_r <= full[2*DATA_W-1:FRAC_BITS];
    end
  end

  assign dn_valid = v_r;
  assign dn_tag   = tag_r;
  assign dn_ops   = ops_r;
  assign dn_sum   = sum_r;
  assign dn_prod  = prod_r;

endmodule

`default_nettype wire

FILE: rtl/core/star_stencil_2d_accumulate.sv
// ----------------------------------------------------------------------------
// star_stencil_2d_accumulate: star stencil with accumulation into the output
// Streams a haloed grid in raster order, weights the vertical and horizontal
// arms of the point RADIUS_PTS rows up, and adds the sum to its prior output.
//
//   Port group  Dir  Handshake             Beat
//   cfg_*       in   cfg_we (no wait)      register index, write data
//   in_*        in   in_valid / in_stall   sst_in_t: weight load or sample
//   out_*       out  out_valid / out_stall sst_out_t: value, column, row, clip
//
// One beat per cycle unless out_stall backs up the chain; each of the
// 2*RADIUS_PTS line-store RAMs does two reads per accepted sample, and only
// the store of the current row is written. A beat passes one operand stage,
// one cell per weight and one saturation stage on its way to out_valid.
// Reset is synchronous; the line stores hold no reset value and get no sweep.
// out_stall holds the chain back stage by stage; empty stages keep absorbing
// beats, so in_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module star_stencil_2d_accumulate #(
  parameter int RADIUS_PTS = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sst_pkg::sst_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sst_pkg::sst_out_t              out_data
);

  import sst_pkg::*;

  localparam int NW    = 4 * RADIUS_PTS + 1;
  localparam int SUM_W = PROD_W + $clog2(NW + 1);

  logic                      c_valid [NW+1];
  logic                      c_stall [NW+1];
  sst_tag_t                  c_tag   [NW+1];
  logic [NW-1:0][DATA_W-1:0] c_ops   [NW];
  logic signed [SUM_W-1:0]   c_sum   [NW+1];
  logic signed [PROD_W-1:0]  c_prod  [NW+1];
  logic signed [DATA_W-1:0]  prior;

  logic                      out_valid_r;
  sst_out_t                  out_data_r;
  logic                      out_adv;
  logic signed [SUM_W-1:0]   total;
  logic [SUM_W-DATA_W:0]     hi;
  logic                      in_range;
  logic [DATA_W-1:0]         sat;

  // position, line stores and operands
  sst_window #(
    .RADIUS    (RADIUS_PTS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .dn_valid  (c_valid[0]),
    .dn_stall  (c_stall[0]),
    .dn_tag    (c_tag[0]),
    .dn_ops    (c_ops[0]),
    .dn_prior  (prior)
  );

  // prior output seeds the running sum
  assign c_sum[0]  = SUM_W'(prior);
  assign c_prod[0] = '0;

  // chain of weight cells
  for (genvar k = 0; k < NW; k++) begin : g_cell
    if (k < NW - 1) begin : g_mid
      sst_cell #(
        .IDX   (k),
        .NW    (NW),
        .SUM_W (SUM_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (c_valid[k]),
        .up_stall (c_stall[k]),
        .up_tag   (c_tag[k]),
        .up_ops   (c_ops[k]),
        .up_sum   (c_sum[k]),
        .up_prod  (c_prod[k]),
        .dn_valid (c_valid[k+1]),
        .dn_stall (c_stall[k+1]),
        .dn_tag   (c_tag[k+1]),
        .dn_ops   (c_ops[k+1]),
        .dn_sum   (c_sum[k+1]),
        .dn_prod  (c_prod[k+1])
      );
    end else begin : g_last
      sst_cell #(
        .IDX   (k),
        .NW    (NW),
        .SUM_W (SUM_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (c_valid[k]),
        .up_stall (c_stall[k]),
        .up_tag   (c_tag[k]),
        .up_ops   (c_ops[k]),
        .up_sum   (c_sum[k]),
        .up_prod  (c_prod[k]),
        .dn_valid (c_valid[k+1]),
        .dn_stall (c_stall[k+1]),
        .dn_tag   (c_tag[k+1]),
        .dn_ops   (),
        .dn_sum   (c_sum[k+1]),
        .dn_prod  (c_prod[k+1])
      );
    end
  end

  // add the last product and saturate
  assign total    = c_sum[NW] + SUM_W'(c_prod[NW]);
  assign hi       = total[SUM_W-1:DATA_W-1];
  assign in_range = (&hi) || !(|hi);
  assign sat      = in_range ? total[DATA_W-1:0]
                  : (total[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}});

  assign out_adv     = !out_valid_r || !out_stall;
  assign c_stall[NW] = !out_adv;

  // output valid; drop beats that produce no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= c_valid[NW] && c_tag[NW].emit;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_adv && c_valid[NW]) begin
      out_data_r.out_value <= sat;
      out_data_r.out_col   <= c_tag[NW].col;
      out_data_r.out_row   <= c_tag[NW].row;
      out_data_r.clipped   <= !in_range;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for star_stencil_2d_accumulate
// Streams weight loads and raster samples through the block, predicts every
// accumulated stencil point in a scoreboard and compares each output beat
// field by field, under random sender bursts and receiver stall patterns.
// ----------------------------------------------------------------------------

module testbench;

  import sst_pkg::*;

  localparam int RADIUS     = 2;
  localparam int LINE_LEN   = 1024;
  localparam int N_WEIGHTS  = 4 * RADIUS + 1;
  localparam int STORE_ROWS = 2 * RADIUS;
  localparam int ROW_SPAN   = 4096;
  localparam int LATENCY    = 4 * RADIUS + 2;
  localparam int N_PHASES   = 8;
  // widest row that can reach an emitted point; the first fill covers it
  localparam int FILL_W     = 40;
  localparam longint LIMIT_NS = 64'd4_000_000;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks weights, line store and raster position, and keeps the
  // stencil points still owed by the block.
  // --------------------------------------------------------------------------
  class stencil_board;
    logic [GW_W-1:0] grid_width;
    logic [FC_W-1:0] first_col;
    logic [EC_W-1:0] end_col;
    logic [FR_W-1:0] first_row;
    logic [ER_W-1:0] end_row;
    logic signed [DATA_W-1:0] weights [N_WEIGHTS];
    logic signed [DATA_W-1:0] lines [STORE_ROWS * LINE_LEN];
    int unsigned col_pos;
    int unsigned row_pos;
    sst_out_t due_points [$];
    int errors;

    function new();
      grid_width = GW_RST;
      first_col  = FC_RST;
      end_col    = EC_RST;
      first_row  = FR_RST;
      end_row    = ER_RST;
      foreach (weights[i]) weights[i] = '0;
      foreach (lines[i]) lines[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH: grid_width = data[GW_W-1:0];
        REG_FIRST_COL:  first_col  = data[FC_W-1:0];
        REG_END_COL:    end_col    = data[EC_W-1:0];
        REG_FIRST_ROW:  first_row  = data[FR_W-1:0];
        REG_END_ROW:    end_row    = data[ER_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned slot_of(int unsigned row, int unsigned col);
      return (row % STORE_ROWS) * LINE_LEN + (col % LINE_LEN);
    endfunction

    // Q16.16 product, low fraction bits dropped (floor)
    function longint scaled_product(logic signed [DATA_W-1:0] a,
                                    logic signed [DATA_W-1:0] b);
      longint full;
      full = longint'(a) * longint'(b);
      return full >>> FRAC_BITS;
    endfunction

    // Apply one accepted input beat and queue the point it completes, if any
    function void take_beat(sst_in_t beat);
      int unsigned w, x, y, px, py;
      longint acc;
      logic clip;
      sst_out_t point;
      if (beat.opcode == OP_WEIGHT) begin
        if (beat.weight_slot < N_WEIGHTS) weights[beat.weight_slot] = beat.weight_value;
        return;
      end
      w = grid_width;
      if (w == 0) w = 1;
      if (w > LINE_LEN) w = LINE_LEN;
      x = col_pos;
      y = row_pos;
      if (y >= STORE_ROWS && x >= RADIUS && x + RADIUS < w) begin
        px = x;
        py = y - RADIUS;
        if (px >= first_col && px < end_col && py >= first_row && py < end_row) begin
          acc = longint'(beat.prior_out);
          // vertical arm: stored rows above, then the arriving sample
          for (int k = 0; k < STORE_ROWS; k++)
            acc += scaled_product(weights[k], lines[slot_of(y - STORE_ROWS + k, x)]);
          acc += scaled_product(weights[STORE_ROWS], beat.sample);
          // horizontal arm on the center row
          for (int k = 0; k < RADIUS; k++) begin
            acc += scaled_product(weights[STORE_ROWS + 1 + k],
                                  lines[slot_of(py, x - RADIUS + k)]);
            acc += scaled_product(weights[3 * RADIUS + 1 + k],
                                  lines[slot_of(py, x + 1 + k)]);
          end
          clip = 1'b0;
          if (acc > Q_MAX) begin
            acc  = Q_MAX;
            clip = 1'b1;
          end else if (acc < Q_MIN) begin
            acc  = Q_MIN;
            clip = 1'b1;
          end
          point.out_value = DATA_W'(acc);
          point.out_col   = COL_OUT_W'(px);
          point.out_row   = ROW_W'(py);
          point.clipped   = clip;
          due_points.push_back(point);
        end
      end
      lines[slot_of(y, x)] = beat.sample;
      // advance the raster position
      if (x + 1 >= w) begin
        col_pos = 0;
        row_pos = (y + 1) % ROW_SPAN;
      end else begin
        col_pos = x + 1;
      end
    endfunction

    function void check_result(sst_out_t got);
      sst_out_t want;
      if (due_points.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: value %h col %0d row %0d clip %b",
                   got.out_value, got.out_col, got.out_row, got.clipped);
        return;
      end
      want = due_points.pop_front();
      if (got.out_value !== want.out_value || got.out_col !== want.out_col ||
          got.out_row !== want.out_row || got.clipped !== want.clipped) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %h col %0d row %0d clip %b, got %h %0d %0d %b",
                   want.out_value, want.out_col, want.out_row, want.clipped,
                   got.out_value, got.out_col, got.out_row, got.clipped);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  sst_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sst_out_t              out_data;

  stencil_board board = new();

  int   burst_left  = 0;
  int   hold_orders = 0;
  logic drain       = 1'b0;

  star_stencil_2d_accumulate #(
    .RADIUS_PTS(RADIUS),
    .MAX_WIDTH (LINE_LEN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // check every accepted output beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // --------------------------------------------------------------------------
  // Receiver: hold-offs on request, otherwise free, random or periodic stalls
  // --------------------------------------------------------------------------
  int       hold_seen = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode   = RX_FREE;
  int       mode_left = 0;
  int       stall_pct = 0;
  int       rx_period = 2;
  int       rx_duty   = 1;
  int       rx_tick   = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_orders) begin
      hold_seen = hold_orders;
      hold_left = $urandom_range(250, 400);
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 300);
      stall_pct = $urandom_range(10, 70);
      rx_period = $urandom_range(2, 9);
      rx_duty   = $urandom_range(1, rx_period - 1);
    end
    mode_left--;
    rx_tick = (rx_tick + 1) % rx_period;
    if (drain) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < stall_pct);
        RX_PERIODIC: out_stall <= (rx_tick < rx_duty);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Q16.16 value: mostly within +-mag, some full range, some extremes
  function automatic logic signed [DATA_W-1:0] pick_q16(int unsigned full_pct,
                                                        int unsigned mag);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (roll < 6 + full_pct) return DATA_W'($urandom);
    return DATA_W'($urandom_range(0, 2 * mag) - mag);
  endfunction

  // weight load; sample and prior carry noise that the block must ignore
  function automatic sst_in_t weight_beat(int unsigned slot, logic signed [DATA_W-1:0] value);
    sst_in_t beat;
    beat.opcode       = OP_WEIGHT;
    beat.weight_slot  = SLOT_W'(slot);
    beat.weight_value = value;
    beat.sample       = DATA_W'($urandom);
    beat.prior_out    = DATA_W'($urandom);
    return beat;
  endfunction

  function automatic sst_in_t sample_beat();
    sst_in_t beat;
    beat.opcode       = OP_SAMPLE;
    beat.weight_slot  = SLOT_W'($urandom);
    beat.weight_value = DATA_W'($urandom);
    beat.sample       = pick_q16(20, 8 << FRAC_BITS);
    beat.prior_out    = pick_q16(25, 64 << FRAC_BITS);
    return beat;
  endfunction

  // offer one beat within the current burst and hold it until accepted
  task automatic send_beat(input sst_in_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_beat(beat);
  endtask

  // drop valid, let every owed point come out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    drain    <= 1'b1;
    do @(posedge clk); while (board.due_points.size() != 0);
    repeat (2 * LATENCY) @(posedge clk);
    drain      <= 1'b0;
    burst_left = 0;
  endtask

  // write all five registers, sometimes followed by an unused index
  task automatic apply_window(int unsigned gw, int unsigned fc, int unsigned ec,
                              int unsigned fr, int unsigned er);
    logic [CFG_IDX_W-1:0]  regs [6];
    logic [CFG_DATA_W-1:0] vals [6];
    int                    n_writes;
    regs = '{REG_GRID_WIDTH, REG_FIRST_COL, REG_END_COL, REG_FIRST_ROW, REG_END_ROW,
             CFG_IDX_W'(REG_END_ROW + 1 + $urandom_range(0, 2))};
    vals = '{CFG_DATA_W'(gw), CFG_DATA_W'(fc), CFG_DATA_W'(ec), CFG_DATA_W'(fr),
             CFG_DATA_W'(er), CFG_DATA_W'($urandom)};
    n_writes = ($urandom_range(0, 3) == 0) ? 6 : 5;
    for (int i = 0; i < n_writes; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // random mix of samples and weight loads with occasional hold-offs and pauses
  task automatic stream_items(int unsigned count, int unsigned weight_pct);
    int unsigned slot;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) hold_orders <= hold_orders + 1;
      if ($urandom_range(0, 249) == 0) settle();
      if ($urandom_range(0, 99) < weight_pct) begin
        slot = ($urandom_range(0, 9) == 0) ? $urandom_range(N_WEIGHTS, 15)
                                           : $urandom_range(0, N_WEIGHTS - 1);
        send_beat(weight_beat(slot, pick_q16(5, 2 << FRAC_BITS)));
      end else begin
        send_beat(sample_beat());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [DATA_W-1:0] edge_weights [N_WEIGHTS];
    int unsigned gw, fc, ec, fr, er, n_items;
    edge_weights = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 32'shFFFF_0000,
                     32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_8000,
                     32'sh0002_0000};
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // narrow the row length; the rest of the window keeps its reset values
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_GRID_WIDTH;
    cfg_wdata <= CFG_DATA_W'(FILL_W);
    @(posedge clk);
    board.write_reg(REG_GRID_WIDTH, CFG_DATA_W'(FILL_W));
    cfg_we <= 1'b0;

    // extreme weights and two out-of-range slots
    for (int k = 0; k < N_WEIGHTS; k++) send_beat(weight_beat(k, edge_weights[k]));
    send_beat(weight_beat(15, 32'sh7FFF_FFFF));
    send_beat(weight_beat(N_WEIGHTS, 32'sh8000_0000));

    // fill the line store across the widest row used later
    for (int i = 0; i < STORE_ROWS * FILL_W; i++) send_beat(sample_beat());

    // first emitting row: hold-off, pause, then soften the weights
    for (int c = 0; c < FILL_W; c++) begin
      if (c == 4) hold_orders <= hold_orders + 1;
      if (c == 30) settle();
      if (c == 34)
        for (int k = 0; k < N_WEIGHTS; k++)
          send_beat(weight_beat(k, pick_q16(0, 2 << FRAC_BITS)));
      send_beat(sample_beat());
    end

    // stop mid-row so the next width ends the row early
    for (int c = 0; c < 20; c++) send_beat(sample_beat());
    settle();

    // window phases: fixed extremes first, then random settings
    for (int p = 0; p < N_PHASES; p++) begin
      n_items = $urandom_range(40, 70);
      case (p)
        0: begin
          gw = 20; fc = 0; ec = 1024; fr = 0; er = 4096;
        end
        1: begin
          gw = 1; fc = 1023; ec = 0; fr = 4095; er = 0;
        end
        2: begin
          gw = 2047; fc = 1; ec = FILL_W - RADIUS; fr = 0; er = 4096;
        end
        3: begin
          gw = 5; fc = 2; ec = 3; fr = 0; er = 4096;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       gw = $urandom_range(0, 4);
            1:       gw = $urandom_range(25, FILL_W);
            default: gw = $urandom_range(5, 24);
          endcase
          case ($urandom_range(0, 9))
            0:       fc = $urandom_range(0, 1023);
            1, 2:    fc = $urandom_range(0, gw);
            default: fc = $urandom_range(0, 3);
          endcase
          case ($urandom_range(0, 9))
            0:       ec = $urandom_range(0, 1024);
            1, 2, 3: ec = $urandom_range(fc, gw);
            default: ec = 1024;
          endcase
          case ($urandom_range(0, 9))
            0:       fr = $urandom_range(0, 4095);
            1, 2:    fr = (board.row_pos + $urandom_range(0, 6)) % ROW_SPAN;
            default: fr = 0;
          endcase
          case ($urandom_range(0, 9))
            0:       er = $urandom_range(0, 4096);
            1, 2, 3: er = board.row_pos + $urandom_range(2, 12);
            default: er = 4096;
          endcase
          if (er > 4096) er = 4096;
        end
      endcase
      apply_window(gw, fc, ec, fr, er);
      stream_items(n_items, 8);
      settle();
    end

    // close with a narrow grid
    apply_window(6, 0, 1024, 0, 4096);
    stream_items(6 * 8, 4);
    settle();

    if (board.errors == 0 && board.due_points.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
